/* rtl/best_first_open_closed_list_core_defines.svh */
// assertion macros used by the open/closed list top level
`ifndef BEST_FIRST_OPEN_CLOSED_LIST_CORE_DEFINES_SVH
`define BEST_FIRST_OPEN_CLOSED_LIST_CORE_DEFINES_SVH

// clocked assertion, ignored while reset is applied
`define BFOC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BFOC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/bfoc_pkg.sv */
// shared types and constants of the open/closed list
`timescale 1ns / 1ps
package bfoc_pkg;

    localparam int NUM_STATES_DEF    = 1024;
    localparam int HEUR_BITS_DEF     = 16;
    localparam int NUM_OPERATORS_DEF = 4096;

    // request codes
    typedef enum logic [2:0] {
        REQ_OPEN    = 3'd0,
        REQ_REOPEN  = 3'd1,
        REQ_CLOSE   = 3'd2,
        REQ_EXTRACT = 3'd3,
        REQ_CLEAR   = 3'd4,
        REQ_LOOKUP  = 3'd5
    } req_code_t;

    // node status codes
    typedef enum logic [1:0] {
        ST_NEW    = 2'd0,
        ST_OPEN   = 2'd1,
        ST_CLOSED = 2'd2
    } node_st_t;

    // command broadcast along the queue cells
    typedef struct packed {
        logic ins;
        logic rem;
        logic pop;
    } q_cmd_t;

endpackage

/* rtl/bfoc_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module bfoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bfoc_cell.sv */
// one cell of the sorted open queue
`timescale 1ns / 1ps
module bfoc_cell import bfoc_pkg::*; #(
    parameter int KW = 26
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  q_cmd_t        cmd,
    input  logic [KW-1:0] key,
    input  logic          left_gt,
    input  logic          left_v,
    input  logic [KW-1:0] left_k,
    input  logic          right_v,
    input  logic [KW-1:0] right_k,
    output logic          v,
    output logic [KW-1:0] k,
    output logic          gt
);

    logic          v_reg, v_next;
    logic [KW-1:0] k_reg, k_next;

    // empty cells sort after every key
    assign gt = !v_reg || (k_reg > key);

    // shift toward the tail on insert, toward the head on removal
    always_comb begin
        v_next = v_reg;
        k_next = k_reg;
        if (cmd.ins && gt) begin
            if (left_gt) begin
                v_next = left_v;
                k_next = left_k;
            end else begin
                v_next = 1'b1;
                k_next = key;
            end
        end else if (cmd.pop || (cmd.rem && v_reg && (k_reg >= key))) begin
            v_next = right_v;
            k_next = right_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
        k_reg <= k_next;
    end

    assign v = v_reg;
    assign k = k_reg;

endmodule

/* rtl/bfoc_queue.sv */
// chain of cells holding open nodes sorted by heuristic then id
`timescale 1ns / 1ps
module bfoc_queue import bfoc_pkg::*; #(
    parameter int NS = NUM_STATES_DEF,
    parameter int KW = 26
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  q_cmd_t        cmd,
    input  logic [KW-1:0] key,
    output logic          head_v,
    output logic [KW-1:0] head_k
);

    logic          v  [NS];
    logic [KW-1:0] k  [NS];
    logic          gt [NS];

    // each cell sees its left and right neighbors, the end cells see empty slots
    for (genvar i = 0; i < NS; i++) begin : g_cell
        logic          lgt, lv, rv;
        logic [KW-1:0] lk, rk;
        if (i == 0) begin : g_first
            assign lgt = 1'b0;
            assign lv  = 1'b0;
            assign lk  = '0;
        end else begin : g_mid
            assign lgt = gt[i-1];
            assign lv  = v[i-1];
            assign lk  = k[i-1];
        end
        if (i == NS - 1) begin : g_last
            assign rv = 1'b0;
            assign rk = '0;
        end else begin : g_inner
            assign rv = v[i+1];
            assign rk = k[i+1];
        end
        bfoc_cell #(.KW(KW)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .key     (key),
            .left_gt (lgt),
            .left_v  (lv),
            .left_k  (lk),
            .right_v (rv),
            .right_k (rk),
            .v       (v[i]),
            .k       (k[i]),
            .gt      (gt[i])
        );
    end

    assign head_v = v[0];
    assign head_k = k[0];

endmodule

/* rtl/best_first_open_closed_list_core.sv */
// top level of the best-first open/closed list
//
// channel   dir  tdata                                   tuser
// s_        in   node, parent, operator, heuristic       request code
// m_        out  node, parent, operator, heuristic,      ok
//                status, open count
//
// after reset a clearing pass writes every node record, with s_tready
// low. one request at a time: the accept edge starts the ram read, the next
// cycle updates the tables and loads the result register, so with no stall a
// request goes through accept, update and result.
// clear open pops the cell chain one node per cycle.
// a new request is taken once the previous result has been delivered.
`timescale 1ns / 1ps
`include "best_first_open_closed_list_core_defines.svh"
module best_first_open_closed_list_core import bfoc_pkg::*; #(
    parameter int NUM_STATES    = NUM_STATES_DEF,
    parameter int HEUR_BITS     = HEUR_BITS_DEF,
    parameter int NUM_OPERATORS = NUM_OPERATORS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node_id, parent_id, operator_index, heuristic_value
    input  logic [55:0] s_tdata,
    // req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_node_id, out_parent_id, out_operator, out_heuristic,
    // node_status, open_count
    output logic [63:0] m_tdata,
    // ok
    output logic [0:0]  m_tuser
);

    localparam int IW    = $clog2(NUM_STATES);
    localparam int CW    = $clog2(NUM_STATES + 1);
    localparam int KW    = HEUR_BITS + IW;
    localparam int RW    = 41;
    localparam int HB16  = (HEUR_BITS < 16) ? HEUR_BITS : 16;
    localparam logic [15:0] HMASK = 16'((17'd1 << HB16) - 17'd1);
    localparam logic [10:0] PAR_NONE = 11'(NUM_STATES);
    localparam logic [12:0] OP_NONE  = 13'(NUM_OPERATORS);

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_EXEC = 4'b0100,
        S_CLR  = 4'b1000
    } fsm_t;

    fsm_t          state_reg, state_next;
    logic [2:0]    req_reg, req_next;
    logic [9:0]    id_reg, id_next;
    logic [10:0]   par_reg, par_next;
    logic [12:0]   op_reg, op_next;
    logic [15:0]   hv_reg, hv_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] init_reg, init_next;
    logic          mv_reg, mv_next;
    logic [63:0]   md_reg, md_next;
    logic          mok_reg, mok_next;

    logic          st_we, rec_we;
    logic [IW-1:0] waddr, raddr;
    logic [1:0]    st_wdata, st_rdata;
    logic [RW-1:0] rec_wdata, rec_rdata;
    q_cmd_t        qcmd;
    logic [KW-1:0] qkey;
    logic          head_v;
    logic [KW-1:0] head_k;

    logic          s_acc;
    logic          id_bad;
    logic [10:0]   r_par;
    logic [12:0]   r_op;
    logic [16:0]   r_heur, n_heur;

    assign s_acc  = s_tvalid && s_tready;
    assign r_par  = rec_rdata[40:30];
    assign r_op   = rec_rdata[29:17];
    assign r_heur = rec_rdata[16:0];
    assign n_heur = {1'b0, hv_reg & HMASK};
    assign id_bad = ({7'd0, id_reg} >= 17'(NUM_STATES));

    // node records: status, and parent / operator / heuristic
    bfoc_ram #(.WIDTH(2), .DEPTH(NUM_STATES)) u_st_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    bfoc_ram #(.WIDTH(RW), .DEPTH(NUM_STATES)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (waddr),
        .wdata (rec_wdata),
        .raddr (raddr),
        .rdata (rec_rdata)
    );

    // open queue
    bfoc_queue #(.NS(NUM_STATES), .KW(KW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (qcmd),
        .key     (qkey),
        .head_v  (head_v),
        .head_k  (head_k)
    );

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign raddr    = (s_tuser == REQ_EXTRACT) ? head_k[IW-1:0] : IW'(s_tdata[9:0]);

    // request sequencer
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        id_next    = id_reg;
        par_next   = par_reg;
        op_next    = op_reg;
        hv_next    = hv_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        init_next  = init_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mok_next   = mok_reg;
        st_we      = 1'b0;
        rec_we     = 1'b0;
        waddr      = addr_reg;
        st_wdata   = ST_NEW;
        rec_wdata  = {r_par, r_op, r_heur};
        qcmd       = '0;
        qkey       = {HEUR_BITS'(r_heur[15:0]), addr_reg};

        unique case (state_reg)
            S_INIT: begin
                st_we     = 1'b1;
                rec_we    = 1'b1;
                waddr     = init_reg;
                st_wdata  = ST_NEW;
                rec_wdata = {PAR_NONE, OP_NONE, 17'h1FFFF};
                init_next = init_reg + 1'b1;
                if (init_reg == IW'(NUM_STATES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    req_next   = s_tuser;
                    id_next    = s_tdata[9:0];
                    par_next   = s_tdata[20:10];
                    op_next    = s_tdata[33:21];
                    hv_next    = s_tdata[49:34];
                    addr_next  = raddr;
                    state_next = (s_tuser == REQ_CLEAR) ? S_CLR : S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                mv_next    = 1'b1;
                mok_next   = 1'b0;
                md_next    = {11'(count_reg), ST_NEW, 17'h1FFFF, 13'd0, 11'd0, 10'd0};
                if (req_reg == REQ_EXTRACT) begin
                    if (head_v) begin
                        st_we      = 1'b1;
                        st_wdata   = ST_CLOSED;
                        qcmd.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                        mok_next   = 1'b1;
                        md_next    = {11'(count_next), ST_CLOSED, r_heur, r_op, r_par,
                                      10'(addr_reg)};
                    end
                end else if (req_reg <= REQ_LOOKUP && !id_bad) begin
                    md_next = {11'(count_reg), st_rdata, r_heur, r_op, r_par, id_reg};
                    case (req_reg) inside
                        REQ_OPEN, REQ_REOPEN: begin
                            if (st_rdata == ((req_reg == REQ_OPEN) ? ST_NEW : ST_CLOSED))
                            begin
                                st_we      = 1'b1;
                                rec_we     = 1'b1;
                                st_wdata   = ST_OPEN;
                                rec_wdata  = {par_reg, op_reg, n_heur};
                                qcmd.ins   = 1'b1;
                                qkey       = {HEUR_BITS'(n_heur[15:0]), addr_reg};
                                count_next = count_reg + 1'b1;
                                mok_next   = 1'b1;
                                md_next    = {11'(count_next), ST_OPEN, n_heur, op_reg,
                                              par_reg, id_reg};
                            end
                        end
                        REQ_CLOSE: begin
                            if (st_rdata == ST_OPEN) begin
                                st_we      = 1'b1;
                                st_wdata   = ST_CLOSED;
                                qcmd.rem   = 1'b1;
                                count_next = count_reg - 1'b1;
                                mok_next   = 1'b1;
                                md_next    = {11'(count_next), ST_CLOSED, r_heur, r_op,
                                              r_par, id_reg};
                            end
                        end
                        default: begin
                            mok_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLR: begin
                if (head_v) begin
                    st_we    = 1'b1;
                    waddr    = head_k[IW-1:0];
                    st_wdata = ST_NEW;
                    qcmd.pop = 1'b1;
                end else begin
                    count_next = '0;
                    state_next = S_IDLE;
                    mv_next    = 1'b1;
                    mok_next   = 1'b1;
                    md_next    = {11'd0, ST_NEW, 17'h1FFFF, 13'd0, 11'd0, 10'd0};
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            count_reg <= '0;
            init_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            init_reg  <= init_next;
            mv_reg    <= mv_next;
        end
        req_reg  <= req_next;
        id_reg   <= id_next;
        par_reg  <= par_next;
        op_reg   <= op_next;
        hv_reg   <= hv_next;
        addr_reg <= addr_next;
        md_reg   <= md_next;
        mok_reg  <= mok_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mok_reg;

    `BFOC_ASSERT(a_count_range, count_reg <= CW'(NUM_STATES), "open count out of range")
    `BFOC_ASSERT(a_head_count, (state_reg == S_IDLE) |-> (head_v == (count_reg != '0)),
        "queue head disagrees with open count")
    `BFOC_ASSERT(a_result_src, $rose(m_tvalid) |-> ($past(state_reg) == S_EXEC ||
        $past(state_reg) == S_CLR), "result raised outside update")
    `BFOC_ASSERT(a_clr_count, (state_reg == S_CLR && !head_v) |=> (count_reg == '0),
        "clear left open nodes counted")

endmodule
